>>> rtl/sensor_coverage_revisit_tracker_defines.svh
// Assertion macros for the coverage revisit tracker.
// Used by the top level only; no other dependencies.
`ifndef SENSOR_COVERAGE_REVISIT_TRACKER_DEFINES_SVH
`define SENSOR_COVERAGE_REVISIT_TRACKER_DEFINES_SVH

// antecedent holds -> consequent in the same cycle
`define SCRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scrt assertion failed");

// antecedent holds -> consequent in the next cycle
`define SCRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scrt assertion failed");

`endif

>>> rtl/scrt_pkg.sv
// Shared constants and types for the coverage revisit tracker.
// No dependencies.
`timescale 1ns / 1ps
package scrt_pkg;
    localparam int MAX_CELLS  = 4096;
    localparam int CELL_AW    = $clog2(MAX_CELLS);
    localparam int CELLS_W    = $clog2(MAX_CELLS + 1);
    localparam int ANGLE_BITS = 16;
    localparam int TRIG_W     = 18;
    localparam int TRIG_LAT   = 5;
    localparam int QDEPTH     = 2;
    localparam int QAW        = $clog2(QDEPTH);
    localparam int QCW        = $clog2(QDEPTH + 1);
    localparam logic [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    localparam logic [1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_CELLS     = 2'd1;

    typedef struct packed {
        logic [1:0]         operation;
        logic [CELL_AW-1:0] cell_index;
        logic [15:0]        cell_lat;
        logic [15:0]        cell_lon;
        logic [31:0]        time_now;
        logic [15:0]        sat_lat;
        logic [15:0]        sat_lon;
    } t_cmd;

    typedef struct packed {
        logic idle;
        logic load_wr;
        logic walk_wr;
        logic q_done;
    } t_bstat;
endpackage

>>> rtl/scrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module scrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/scrt_trig.sv
// Pipelined binary-angle sine, polynomial in Q15, five register stages.
// Depends on scrt_pkg.
`timescale 1ns / 1ps
module scrt_trig
    import scrt_pkg::*;
(
    input  logic                     i_clk,
    input  logic [ANGLE_BITS-1:0]    i_ang,
    output logic signed [TRIG_W-1:0] o_sin
);
    logic [1:0]              q;
    logic [ANGLE_BITS-2:0]   rr;
    logic [ANGLE_BITS+14:0]  xw;
    logic [31:0]             p1, p2, p3, p4;
    logic [27:0]             pk;

    logic [15:0] r_x0, r_x1, r_x2, r_x3;
    logic        r_n0, r_n1, r_n2, r_n3;
    logic [15:0] r_sq1, r_sq2;
    logic [15:0] r_t2, r_t3;
    logic signed [TRIG_W-1:0] r_out;

    always_comb begin
        q  = i_ang[ANGLE_BITS-1:ANGLE_BITS-2];
        rr = {1'b0, i_ang[ANGLE_BITS-3:0]};
        if (q[0]) begin
            rr = QUARTER[ANGLE_BITS-2:0] - {1'b0, i_ang[ANGLE_BITS-3:0]};
        end
        xw = {rr, 15'b0} >> (ANGLE_BITS - 2);
        p1 = r_x0 * r_x0;
        pk = 28'd2320 * {12'd0, r_sq1};
        p3 = {16'd0, r_t2} * {16'd0, r_sq2};
        p4 = {16'd0, r_t3} * {16'd0, r_x3};
        p2 = 32'(21024) - {17'd0, pk[27:15]};
    end

    always_ff @(posedge i_clk) begin
        r_x0  <= xw[15:0];
        r_n0  <= q[1];
        r_sq1 <= p1[30:15];
        r_x1  <= r_x0;
        r_n1  <= r_n0;
        r_t2  <= p2[15:0];
        r_sq2 <= r_sq1;
        r_x2  <= r_x1;
        r_n2  <= r_n1;
        r_t3  <= 16'(32'(51472) - {15'd0, p3[31:15]});
        r_x3  <= r_x2;
        r_n3  <= r_n2;
        r_out <= r_n3 ? -$signed({1'b0, p4[31:15]}) : $signed({1'b0, p4[31:15]});
    end

    assign o_sin = r_out;
endmodule

>>> rtl/scrt_front.sv
// Front end: accepts input words, drops unused operations, queues commands.
// Depends on scrt_pkg.
`timescale 1ns / 1ps
module scrt_front
    import scrt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_cmd,
    output t_cmd o_cmd,
    output logic o_cmd_valid,
    input  logic i_pop
);
    t_cmd           r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;
    logic           acc, push, pop;

    assign o_stall     = (r_cnt == QCW'(QDEPTH));
    assign acc         = i_valid && !o_stall;
    assign push        = acc && (i_cmd.operation != OP_NONE);
    assign o_cmd_valid = (r_cnt != '0);
    assign pop         = i_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= QAW'((r_wp + 1'b1) % QDEPTH);
            end
            if (pop) begin
                r_rp <= QAW'((r_rp + 1'b1) % QDEPTH);
            end
            r_cnt <= QCW'(r_cnt + QCW'(push) - QCW'(pop));
        end
    end
endmodule

>>> rtl/scrt_back.sv
// Back end: cell stores, tick walk through trig and product pipeline, queries.
// Depends on scrt_pkg, scrt_ram, scrt_trig.
`timescale 1ns / 1ps
module scrt_back
    import scrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_pop,
    input  logic signed [31:0] i_thr,
    input  logic [CELLS_W-1:0] i_cells,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_age,
    output logic               o_never_seen,
    output t_bstat             o_stat
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SAT   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_QRES  = 3'd4;
    localparam int PIPE = TRIG_LAT + 3;

    logic [2:0]         r_state;
    logic [CELLS_W-1:0] r_cnt, walk_len;
    logic [15:0]        r_slat, r_slon;
    logic [31:0]        r_time;
    logic signed [TRIG_W-1:0] r_ss, r_cs, r_cd;
    logic signed [2*TRIG_W-1:0] r_pa, r_pb, r_sa;
    logic signed [3*TRIG_W-1:0] r_sb;
    logic [PIPE-1:0]    r_v;
    logic [CELL_AW-1:0] r_ix [PIPE];
    logic               r_ovalid, r_onever;
    logic [31:0]        r_age;

    logic               pop, ld, qry, tick, issue, covered, walk_wr, q_done;
    logic [31:0]        ll_rd;
    logic [32:0]        ls_rd;
    logic [ANGLE_BITS-1:0] a0, a1, a2, lat_base;
    logic signed [TRIG_W-1:0] s0, s1, s2;
    logic signed [55:0] sum, clamped, thr_s;

    assign walk_len = (i_cells > CELLS_W'(MAX_CELLS)) ? CELLS_W'(MAX_CELLS) : i_cells;
    assign pop   = (r_state == S_IDLE) && i_cmd_valid;
    assign ld    = pop && (i_cmd.operation == OP_LOAD);
    assign tick  = pop && (i_cmd.operation == OP_TICK);
    assign qry   = pop && (i_cmd.operation == OP_QUERY);
    assign issue = (r_state == S_WALK) && (r_cnt < walk_len);
    assign q_done = (r_state == S_QRES) && (!r_ovalid || !i_stall);

    scrt_ram #(.WIDTH(32), .DEPTH(MAX_CELLS)) u_pos (
        .i_clk   (i_clk),
        .i_we    (ld),
        .i_waddr (i_cmd.cell_index),
        .i_wdata ({i_cmd.cell_lat, i_cmd.cell_lon}),
        .i_re    (issue),
        .i_raddr (r_cnt[CELL_AW-1:0]),
        .o_rdata (ll_rd)
    );

    scrt_ram #(.WIDTH(33), .DEPTH(MAX_CELLS)) u_seen (
        .i_clk   (i_clk),
        .i_we    (ld || walk_wr),
        .i_waddr (ld ? i_cmd.cell_index : r_ix[PIPE-1]),
        .i_wdata (ld ? 33'd0 : {1'b1, r_time}),
        .i_re    (qry),
        .i_raddr (i_cmd.cell_index),
        .o_rdata (ls_rd)
    );

    assign lat_base = (r_state == S_SAT) ? r_slat : ll_rd[31:16];
    assign a0 = lat_base;
    assign a1 = lat_base + QUARTER;
    assign a2 = ll_rd[15:0] - r_slon + QUARTER;

    scrt_trig u_t0 (.i_clk(i_clk), .i_ang(a0), .o_sin(s0));
    scrt_trig u_t1 (.i_clk(i_clk), .i_ang(a1), .o_sin(s1));
    scrt_trig u_t2 (.i_clk(i_clk), .i_ang(a2), .o_sin(s2));

    always_comb begin
        sum = (56'(r_sa) <<< 15) + 56'(r_sb);
        clamped = sum;
        if (sum > (56'sd1 <<< 45)) begin
            clamped = 56'sd1 <<< 45;
        end
        if (sum < -(56'sd1 <<< 45)) begin
            clamped = -(56'sd1 <<< 45);
        end
        thr_s   = 56'(i_thr) <<< 15;
        covered = (clamped >= thr_s);
        walk_wr = r_v[PIPE-1] && covered;
    end

    always_ff @(posedge i_clk) begin
        r_pa <= r_ss * s0;
        r_pb <= r_cs * s1;
        r_cd <= s2;
        r_sa <= r_pa;
        r_sb <= r_pb * r_cd;
        r_ix[0] <= r_cnt[CELL_AW-1:0];
        for (int k = 1; k < PIPE; k++) begin
            r_ix[k] <= r_ix[k-1];
        end
        if (tick) begin
            r_slat <= i_cmd.sat_lat;
            r_slon <= i_cmd.sat_lon;
        end
        if (tick || qry) begin
            r_time <= i_cmd.time_now;
        end
        if ((r_state == S_SAT) && (r_cnt == CELLS_W'(TRIG_LAT))) begin
            r_ss <= s0;
            r_cs <= s1;
        end
        if (q_done) begin
            r_age    <= ls_rd[32] ? (r_time - ls_rd[31:0]) : 32'd0;
            r_onever <= !ls_rd[32];
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_v      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_v <= {r_v[PIPE-2:0], issue};
            if (q_done) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (tick) begin
                        r_state <= S_SAT;
                    end else if (qry) begin
                        r_state <= S_QRES;
                    end
                end
                S_SAT: begin
                    if (r_cnt == CELLS_W'(TRIG_LAT)) begin
                        r_cnt   <= '0;
                        r_state <= S_WALK;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_WALK: begin
                    if (issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r_v == '0) begin
                        r_state <= S_IDLE;
                    end
                end
                S_QRES: begin
                    if (q_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_pop        = pop;
    assign o_valid      = r_ovalid;
    assign o_age        = r_age;
    assign o_never_seen = r_onever;
    assign o_stat       = '{idle: (r_state == S_IDLE), load_wr: ld, walk_wr: walk_wr,
                            q_done: q_done};
endmodule

>>> rtl/sensor_coverage_revisit_tracker.sv
// Top level of the coverage revisit tracker: config registers, front, back.
// Depends on scrt_pkg, scrt_front, scrt_back and the defines header.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | i_valid / o_stall  | operation, cell index/lat/lon, time, sat
//  output   | o_valid / i_stall  | o_age, o_never_seen
//  config   | i_cfg_we           | i_cfg_idx, i_cfg_data
//
// Load: writes both cell stores on pop. Query: seen-store read, then output register.
// Tick: S_SAT, then S_WALK, one cell per cycle through the trig pipe, then S_DRAIN.
// Reset is synchronous; the cell stores are not cleared and hold garbage until loaded.
// The two-word queue accepts while the back end walks or the output stalls, until full.
`timescale 1ns / 1ps
`include "sensor_coverage_revisit_tracker_defines.svh"
module sensor_coverage_revisit_tracker
    import scrt_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_operation,
    input  logic [11:0]        i_cell_index,
    input  logic signed [15:0] i_cell_lat,
    input  logic signed [15:0] i_cell_lon,
    input  logic [31:0]        i_time_now,
    input  logic signed [15:0] i_sat_lat,
    input  logic signed [15:0] i_sat_lon,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [31:0]        o_age,
    output logic               o_never_seen,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [31:0]        i_cfg_data
);
    logic signed [31:0] r_thr;
    logic [CELLS_W-1:0] r_cells;
    t_cmd   in_cmd, q_cmd;
    logic   q_valid, q_pop;
    t_bstat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= 32'sh4000_0000;
            r_cells <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_THRESHOLD: r_thr   <= i_cfg_data;
                CFG_CELLS:     r_cells <= i_cfg_data[CELLS_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_cmd = '{operation: i_operation, cell_index: i_cell_index,
                      cell_lat: i_cell_lat, cell_lon: i_cell_lon, time_now: i_time_now,
                      sat_lat: i_sat_lat, sat_lon: i_sat_lon};

    scrt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (in_cmd),
        .o_cmd       (q_cmd),
        .o_cmd_valid (q_valid),
        .i_pop       (q_pop)
    );

    scrt_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (q_cmd),
        .i_cmd_valid  (q_valid),
        .o_pop        (q_pop),
        .i_thr        (r_thr),
        .i_cells      (r_cells),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_age        (o_age),
        .o_never_seen (o_never_seen),
        .o_stat       (stat)
    );

    `SCRT_ASSERT_NOW(a_wr_excl, i_clk, i_rst_n, stat.walk_wr, !stat.load_wr)
    `SCRT_ASSERT_NOW(a_pop_idle, i_clk, i_rst_n, q_pop, stat.idle && q_valid)
    `SCRT_ASSERT_NEXT(a_qdone_out, i_clk, i_rst_n, stat.q_done, o_valid)
endmodule

>>> tb/sensor_coverage_revisit_tracker_test.sv
// Self-checking testbench for sensor_coverage_revisit_tracker.
// Predicts ground-cell coverage and query ages in a scoreboard class, drives the block by tasks.
// Depends on scrt_pkg and the block's RTL.
`timescale 1ns / 1ps
module sensor_coverage_revisit_tracker_test
    import scrt_pkg::*;
();

    class cov_scoreboard;
        logic [15:0] lat_mem [MAX_CELLS];
        logic [15:0] lon_mem [MAX_CELLS];
        logic [31:0] seen_time [MAX_CELLS];
        bit          seen [MAX_CELLS];
        longint      threshold;
        int unsigned cells;
        logic [31:0] age_q [$];
        bit          never_q [$];
        int          errors;

        function new();
            threshold = longint'(1) << 30;
            cells     = 0;
            errors    = 0;
            foreach (seen[i]) begin
                seen[i]      = 0;
                seen_time[i] = 0;
                lat_mem[i]   = 0;
                lon_mem[i]   = 0;
            end
        endfunction

        function int sine(logic [15:0] a);
            longint unsigned r, x, x2, t, m;
            r = a[13:0];
            if (a[14]) r = 16384 - r;
            x  = (r << 15) >> 14;
            x2 = (x * x) >> 15;
            t  = 21024 - ((2320 * x2) >> 15);
            t  = 51472 - ((t * x2) >> 15);
            m  = (t * x) >> 15;
            return a[15] ? -int'(m) : int'(m);
        endfunction

        function int cosine(logic [15:0] a);
            return sine(a + QUARTER);
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] data);
            if (idx == CFG_THRESHOLD) threshold = longint'($signed(data));
            else if (idx == CFG_CELLS) cells = data[12:0];
        endfunction

        function void note_word(logic [1:0] op, logic [11:0] idx, logic [15:0] lat,
                                logic [15:0] lon, logic [31:0] tnow,
                                logic [15:0] slat, logic [15:0] slon);
            longint ss, cs, sc, cc, cd, s, thr;
            int unsigned n;
            if (op == OP_LOAD) begin
                lat_mem[idx]   = lat;
                lon_mem[idx]   = lon;
                seen_time[idx] = 0;
                seen[idx]      = 0;
            end else if (op == OP_TICK) begin
                ss  = sine(slat);
                cs  = cosine(slat);
                thr = threshold * 32768;
                n   = (cells < MAX_CELLS) ? cells : MAX_CELLS;
                for (int i = 0; i < n; i++) begin
                    sc = sine(lat_mem[i]);
                    cc = cosine(lat_mem[i]);
                    cd = cosine(lon_mem[i] - slon);
                    s  = ss * sc * 32768 + cs * cc * cd;
                    if (s > (longint'(1) << 45)) s = longint'(1) << 45;
                    if (s < -(longint'(1) << 45)) s = -(longint'(1) << 45);
                    if (s >= thr) begin
                        seen_time[i] = tnow;
                        seen[i]      = 1;
                    end
                end
            end else if (op == OP_QUERY) begin
                if (seen[idx]) begin
                    age_q.insert(age_q.size(), tnow - seen_time[idx]);
                    never_q.insert(never_q.size(), 1'b0);
                end else begin
                    age_q.insert(age_q.size(), 32'd0);
                    never_q.insert(never_q.size(), 1'b1);
                end
            end
        endfunction

        function void check_word(logic [31:0] age, logic never);
            logic [31:0] ea;
            bit en;
            if (age_q.size() == 0) begin
                $error("unexpected result word age=%0d never_seen=%0d", age, never);
                errors++;
                return;
            end
            ea = age_q.pop_front();
            en = never_q.pop_front();
            if (age !== ea) begin
                $error("age expected %0d actual %0d", ea, age);
                errors++;
            end
            if (never !== en) begin
                $error("never_seen expected %0d actual %0d", en, never);
                errors++;
            end
        endfunction
    endclass

    localparam int LIMIT = 2000000;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic [1:0]         i_operation = 0;
    logic [11:0]        i_cell_index = 0;
    logic signed [15:0] i_cell_lat = 0;
    logic signed [15:0] i_cell_lon = 0;
    logic [31:0]        i_time_now = 0;
    logic signed [15:0] i_sat_lat = 0;
    logic signed [15:0] i_sat_lon = 0;
    logic               o_valid;
    logic               i_stall = 1;
    logic [31:0]        o_age;
    logic               o_never_seen;
    logic               i_cfg_we = 0;
    logic [1:0]         i_cfg_idx = 0;
    logic [31:0]        i_cfg_data = 0;

    cov_scoreboard sb = new();
    int  cycles = 0;
    bit  quiet = 0;
    bit  hold_go = 0;
    bit  long_hold = 0;
    int  out_gap = 0;
    bit  loaded [MAX_CELLS];
    int  loaded_list [$];
    logic [31:0] tnow = 32'd1000;

    sensor_coverage_revisit_tracker dut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_word(o_age, o_never_seen);
    end

    // receiver: random gap per word, plus one long hold-off
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) out_gap = quiet ? 0 : $urandom_range(0, 3);
            i_stall <= long_hold || (out_gap > 0);
            if (out_gap > 0) out_gap--;
        end
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        long_hold <= 1;
        for (int c = 0; c < 300; c++) @(posedge i_clk);
        long_hold <= 0;
    end

    task automatic send(logic [1:0] op, logic [11:0] idx, logic [15:0] lat, logic [15:0] lon,
                        logic [31:0] t, logic [15:0] slat, logic [15:0] slon);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1;
        i_operation  <= op;
        i_cell_index <= idx;
        i_cell_lat   <= lat;
        i_cell_lon   <= lon;
        i_time_now   <= t;
        i_sat_lat    <= slat;
        i_sat_lon    <= slon;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(op, idx, lat, lon, t, slat, slon);
        if (op == OP_LOAD && !loaded[idx]) begin
            loaded[idx] = 1;
            loaded_list.insert(loaded_list.size(), int'(idx));
        end
    endtask

    function automatic logic [15:0] rnd_lat();
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic load_cell(logic [11:0] idx, logic [15:0] lat, logic [15:0] lon);
        send(OP_LOAD, idx, lat, lon, $urandom, $urandom, $urandom);
    endtask

    task automatic tick(logic [31:0] t, logic [15:0] slat, logic [15:0] slon);
        send(OP_TICK, $urandom, $urandom, $urandom, t, slat, slon);
    endtask

    task automatic query(logic [11:0] idx, logic [31:0] t);
        send(OP_QUERY, idx, $urandom, $urandom, t, $urandom, $urandom);
    endtask

    task automatic query_any(logic [31:0] t);
        query(loaded_list[$urandom_range(0, loaded_list.size() - 1)], t);
    endtask

    // up to three ticks can still be in flight: two queued, one walking
    task automatic settle();
        int n;
        n = (sb.cells < MAX_CELLS) ? sb.cells : MAX_CELLS;
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.age_q.size() != 0) @(posedge i_clk);
        repeat (3 * (n + 24)) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        settle();
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 0;
    endtask

    initial begin
        int op_pick;
        foreach (loaded[i]) loaded[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        load_cell(0, 16'sd0, 16'sd0);
        load_cell(1, 16'sd16384, 16'sd32767);
        load_cell(2, -16'sd16384, -16'sd32768);
        load_cell(3, 16'sd100, 16'sd200);
        load_cell(4, -16'sd8192, 16'sd16384);
        load_cell(5, 16'sd4000, -16'sd16384);
        load_cell(6, 16'sd0, -16'sd32768);
        load_cell(7, -16'sd1, 16'sd1);
        load_cell(12'hFFF, 16'sd16384, -16'sd1);
        load_cell(12'h800, -16'sd16384, 16'sd32767);
        query(0, 32'd5);
        send(OP_NONE, 12'hFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(CFG_CELLS, 32'd8);
        tick(32'd100, 16'sd0, 16'sd0);
        query(0, 32'd150);
        query(1, 32'd150);
        write_reg(CFG_THRESHOLD, 32'hC0000000);
        tick(32'hFFFFFFFF, -16'sd16384, -16'sd32768);
        query(3, 32'd10);
        query(12'hFFF, 32'd0);
        write_reg(CFG_THRESHOLD, 32'h7FFFFFFF);
        tick(32'd7, 16'sd0, 16'sd0);
        query(2, 32'd8);
        write_reg(CFG_THRESHOLD, 32'h80000000);
        tick(32'd20, 16'sd16384, 16'sd32767);
        load_cell(3, 16'sd0, 16'sd0);
        query(3, 32'd21);
        query(7, 32'd30);
        write_reg(2'd2, 32'hFFFFFFFF);
        write_reg(2'd3, 32'h12345678);
        write_reg(CFG_CELLS, 32'd0);
        tick(32'd40, 16'sd0, 16'sd0);
        query(5, 32'd41);

        // fill a working set of 32 cells
        for (int i = 0; i < 32; i++) load_cell(i, rnd_lat(), $urandom);

        // random phases
        for (int ph = 0; ph < 5; ph++) begin
            quiet = (ph == 3);
            case ($urandom_range(0, 3))
                0: write_reg(CFG_THRESHOLD, 32'h40000000);
                1: write_reg(CFG_THRESHOLD, 32'hC0000000);
                2: write_reg(CFG_THRESHOLD, $urandom_range(32'h20000000, 32'h40000000));
                default: write_reg(CFG_THRESHOLD, $urandom);
            endcase
            write_reg(CFG_CELLS, (ph == 0) ? 32 : $urandom_range(0, 32));
            for (int k = 0; k < 14; k++) begin
                op_pick = $urandom_range(0, 19);
                if ($urandom_range(0, 7) == 0) tnow = $urandom;
                else tnow = tnow + $urandom_range(0, 500);
                if (op_pick < 4)
                    load_cell(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 31),
                              rnd_lat(), $urandom);
                else if (op_pick < 11) tick(tnow, rnd_lat(), $urandom);
                else if (op_pick < 19) query_any(tnow);
                else send(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
        end
        quiet = 0;

        // receiver holds off while queries pile up
        write_reg(CFG_THRESHOLD, 32'h30000000);
        write_reg(CFG_CELLS, 32'd16);
        tick(tnow, 16'sd0, 16'sd0);
        hold_go = 1;
        for (int k = 0; k < 12; k++) query_any(tnow + k);

        settle();
        if (sb.errors == 0 && sb.age_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
